>>> src/lfjn_pkg.sv
// Package: shared types and constants for the line-follow junction navigator.
`timescale 1ns / 1ps

package lfjn_pkg;

    // Configuration port widths
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // Result field widths
    localparam int SPEED_W = 14;
    localparam int COUNT_W = 9;
    localparam int OUT_W   = 40;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;

    // Fixed wheel commands during a timed turn
    localparam logic signed [SPEED_W-1:0] TURN_SLOW = -14'sd70;
    localparam logic signed [SPEED_W-1:0] TURN_FAST = 14'sd180;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_NODES  = 3'd0,
        REG_TRAVEL_MODE   = 3'd1,
        REG_TRACK_MAX     = 3'd2,
        REG_BOARD_MIN     = 3'd3,
        REG_FORWARD_SPEED = 3'd4,
        REG_STEER_GAIN    = 3'd5,
        REG_TURN_TICKS    = 3'd6
    } t_reg_idx;

    // Travel modes (code 3 drives straight)
    typedef enum logic [1:0] {
        MODE_LEFT     = 2'd0,
        MODE_RIGHT    = 2'd1,
        MODE_STRAIGHT = 2'd2
    } t_mode;

    // Register reset values
    localparam logic [7:0]  RST_TARGET_NODES  = 8'd2;
    localparam logic [1:0]  RST_TRAVEL_MODE   = 2'd2;
    localparam logic [11:0] RST_TRACK_MAX     = 12'd500;
    localparam logic [11:0] RST_BOARD_MIN     = 12'd700;
    localparam logic [9:0]  RST_FORWARD_SPEED = 10'd200;
    localparam logic [7:0]  RST_STEER_GAIN    = 8'd26;
    localparam logic [7:0]  RST_TURN_TICKS    = 8'd25;

    // Configuration register bank contents
    typedef struct packed {
        logic [7:0]  target_nodes;
        logic [1:0]  travel_mode;
        logic [11:0] track_max;
        logic [11:0] board_min;
        logic [9:0]  forward_speed;
        logic [7:0]  steer_gain;
        logic [7:0]  turn_ticks;
    } t_cfg;

    // One result item
    typedef struct packed {
        logic                      leg_done;
        logic                      is_turning;
        logic [COUNT_W-1:0]        junction_count;
        logic                      junction_found;
        logic signed [SPEED_W-1:0] right_speed;
        logic signed [SPEED_W-1:0] left_speed;
    } t_result;

endpackage

>>> src/lfjn_cfg_regs.sv
// Configuration register bank written through the config request channel.
`timescale 1ns / 1ps

module lfjn_cfg_regs
    import lfjn_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr,
    input  logic [CFG_IDX_W-1:0]  i_idx,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Decode the written register
    always_comb begin
        n_cfg = r_cfg;
        if (i_wr) begin
            case (t_reg_idx'(i_idx))
                REG_TARGET_NODES:  n_cfg.target_nodes  = i_data[7:0];
                REG_TRAVEL_MODE:   n_cfg.travel_mode   = i_data[1:0];
                REG_TRACK_MAX:     n_cfg.track_max     = i_data[11:0];
                REG_BOARD_MIN:     n_cfg.board_min     = i_data[11:0];
                REG_FORWARD_SPEED: n_cfg.forward_speed = i_data[9:0];
                REG_STEER_GAIN:    n_cfg.steer_gain    = i_data[7:0];
                REG_TURN_TICKS:    n_cfg.turn_ticks    = i_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_nodes  <= RST_TARGET_NODES;
            r_cfg.travel_mode   <= RST_TRAVEL_MODE;
            r_cfg.track_max     <= RST_TRACK_MAX;
            r_cfg.board_min     <= RST_BOARD_MIN;
            r_cfg.forward_speed <= RST_FORWARD_SPEED;
            r_cfg.steer_gain    <= RST_STEER_GAIN;
            r_cfg.turn_ticks    <= RST_TURN_TICKS;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> src/lfjn_steer.sv
// Proportional steering: Q8 gain times sensor difference, trunc toward zero, saturate.
`timescale 1ns / 1ps

module lfjn_steer
    import lfjn_pkg::*;
#(
    parameter int SENSOR_BITS = 12
) (
    input  logic [SENSOR_BITS-1:0]    i_left,
    input  logic [SENSOR_BITS-1:0]    i_right,
    input  logic [9:0]                i_forward_speed,
    input  logic [7:0]                i_steer_gain,
    output logic signed [SPEED_W-1:0] o_left_cmd,
    output logic signed [SPEED_W-1:0] o_right_cmd
);

    localparam int DIFF_W = SENSOR_BITS + 1;
    localparam int PROD_W = SENSOR_BITS + 10;
    localparam int SUM_W  = SENSOR_BITS + 12;

    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] corr;
    logic signed [SUM_W-1:0]  corr_ext;
    logic signed [SUM_W-1:0]  base;
    logic signed [SUM_W-1:0]  sum_l;
    logic signed [SUM_W-1:0]  sum_r;

    // Quotient by 256 rounding toward zero
    function automatic logic signed [SUM_W-1:0] div256(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] adj;
        adj = v[SUM_W-1] ? (v + SUM_W'(255)) : v;
        return adj >>> 8;
    endfunction

    // Clamp to the 14-bit command range
    function automatic logic signed [SPEED_W-1:0] sat(input logic signed [SUM_W-1:0] q);
        logic fits;
        fits = (&q[SUM_W-1:SPEED_W-1]) | ~(|q[SUM_W-1:SPEED_W-1]);
        if (fits) return q[SPEED_W-1:0];
        return q[SUM_W-1] ? {1'b1, {(SPEED_W-1){1'b0}}} : {1'b0, {(SPEED_W-1){1'b1}}};
    endfunction

    assign diff     = $signed({1'b0, i_right}) - $signed({1'b0, i_left});
    assign corr     = $signed({{(PROD_W-8){1'b0}}, i_steer_gain}) *
                      $signed({{(PROD_W-DIFF_W){diff[DIFF_W-1]}}, diff});
    assign corr_ext = {{(SUM_W-PROD_W){corr[PROD_W-1]}}, corr};
    assign base     = $signed({{(SUM_W-18){1'b0}}, i_forward_speed, 8'b0});
    assign sum_l    = base - corr_ext;
    assign sum_r    = base + corr_ext;

    assign o_left_cmd  = sat(div256(sum_l));
    assign o_right_cmd = sat(div256(sum_r));

endmodule

>>> src/lfjn_nav.sv
// Navigation state: junction detection, counting, timed turns and leg end.
`timescale 1ns / 1ps

module lfjn_nav
    import lfjn_pkg::*;
#(
    parameter int SENSOR_BITS = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_adv,
    input  t_cfg                   i_cfg,
    input  logic [SENSOR_BITS-1:0] i_left,
    input  logic [SENSOR_BITS-1:0] i_center,
    input  logic [SENSOR_BITS-1:0] i_right,
    output t_result                o_res
);

    localparam int CMP_W = (SENSOR_BITS > 12) ? SENSOR_BITS : 12;

    logic [COUNT_W-1:0]        r_cnt, n_cnt;
    logic                      r_onj, n_onj;
    logic                      r_ta, n_ta;
    logic [7:0]                r_cd, n_cd;
    logic                      r_begun, n_begun;
    logic signed [SPEED_W-1:0] r_lh, n_lh;
    logic signed [SPEED_W-1:0] r_rh, n_rh;

    logic signed [SPEED_W-1:0] steer_l, steer_r;
    logic [COUNT_W-1:0] target_ext;
    logic [COUNT_W-1:0] cnt_tick;
    logic on_l, on_c, on_r, off_l, off_r;
    logic sense, all_on, found, left_node, right_turn, turning_leg, turn_now;
    logic pat_ok, done;
    logic [7:0] cd_dec;

    lfjn_steer #(
        .SENSOR_BITS(SENSOR_BITS)
    ) u_steer (
        .i_left         (i_left),
        .i_right        (i_right),
        .i_forward_speed(i_cfg.forward_speed),
        .i_steer_gain   (i_cfg.steer_gain),
        .o_left_cmd     (steer_l),
        .o_right_cmd    (steer_r)
    );

    // Sensor classification; on-line wins over off-line
    assign on_l  = CMP_W'(i_left)   <= CMP_W'(i_cfg.track_max);
    assign on_c  = CMP_W'(i_center) <= CMP_W'(i_cfg.track_max);
    assign on_r  = CMP_W'(i_right)  <= CMP_W'(i_cfg.track_max);
    assign off_l = !on_l && (CMP_W'(i_left)  >= CMP_W'(i_cfg.board_min));
    assign off_r = !on_r && (CMP_W'(i_right) >= CMP_W'(i_cfg.board_min));

    assign target_ext  = {1'b0, i_cfg.target_nodes};
    assign sense       = r_cnt <= target_ext;
    assign all_on      = on_l && on_c && on_r;
    assign found       = sense && !r_onj && all_on;
    assign left_node   = r_onj && !all_on;
    assign right_turn  = i_cfg.travel_mode == MODE_RIGHT;
    assign turning_leg = (i_cfg.travel_mode == MODE_LEFT || right_turn) && (!r_begun || r_ta);
    assign turn_now    = turning_leg && (left_node || r_ta);
    assign cd_dec      = (r_cd != 8'd0) ? (r_cd - 8'd1) : r_cd;
    assign pat_ok      = right_turn ? (on_l && on_c && off_r) : (off_l && on_c && on_r);

    // Per-tick state update and result
    always_comb begin
        n_cnt   = r_cnt;
        n_onj   = r_onj;
        n_ta    = r_ta;
        n_cd    = r_cd;
        n_begun = r_begun;
        n_lh    = r_lh;
        n_rh    = r_rh;
        if (sense) begin
            n_onj = all_on;
            if (found && r_cnt != COUNT_MAX) begin
                n_cnt = r_cnt + COUNT_W'(1);
            end
            if (turn_now) begin
                n_begun = 1'b1;
                if (!r_ta) begin
                    n_ta = 1'b1;
                    n_cd = i_cfg.turn_ticks;
                    n_lh = right_turn ? TURN_FAST : TURN_SLOW;
                    n_rh = right_turn ? TURN_SLOW : TURN_FAST;
                end else begin
                    n_cd = cd_dec;
                    if (cd_dec == 8'd0 && pat_ok) begin
                        n_ta = 1'b0;
                    end
                end
            end else begin
                n_lh = steer_l;
                n_rh = steer_r;
            end
        end
        cnt_tick = n_cnt;
        done     = cnt_tick > target_ext;

        o_res.left_speed     = done ? '0 : n_lh;
        o_res.right_speed    = done ? '0 : n_rh;
        o_res.junction_found = found;
        o_res.junction_count = cnt_tick;
        o_res.is_turning     = n_ta;
        o_res.leg_done       = done;

        // Leg end clears the count and the turn-taken flag
        if (done) begin
            n_cnt   = '0;
            n_begun = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_onj   <= 1'b0;
            r_ta    <= 1'b0;
            r_cd    <= '0;
            r_begun <= 1'b0;
            r_lh    <= '0;
            r_rh    <= '0;
        end else if (i_adv) begin
            r_cnt   <= n_cnt;
            r_onj   <= n_onj;
            r_ta    <= n_ta;
            r_cd    <= n_cd;
            r_begun <= n_begun;
            r_lh    <= n_lh;
            r_rh    <= n_rh;
        end
    end

    // A finished leg always restarts the count
    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && done |=> r_cnt == '0)
        else $error("junction count not cleared after leg end");

    // The count moves by at most one junction per tick
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv |=> (r_cnt == '0) || (r_cnt == $past(r_cnt)) ||
                  (r_cnt == $past(r_cnt) + COUNT_W'(1)))
        else $error("junction count jumped");

    // A turn start loads the countdown from the turn length register
    a_turn_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && !r_ta && n_ta |=> r_ta && r_cd == $past(i_cfg.turn_ticks))
        else $error("turn countdown not loaded on turn start");

endmodule

>>> src/line_follow_junction_navigator_core.sv
// A request waits in the input register, its result in the result register; the nav
// state updates in the single compute stage. Throughput: one request per cycle unless
// the output stalls. Input register and result register decouple the two stream sides.
// Reset (i_rst_n low, synchronous) empties both stages, zeroes the nav state and
// loads the configuration registers with their defaults.
`timescale 1ns / 1ps

module line_follow_junction_navigator_core
    import lfjn_pkg::*;
#(
    parameter int SENSOR_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Sensor request stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [left_reading, center_reading, right_reading], lowest first
    input  logic [((3*SENSOR_BITS+7)/8)*8-1:0] s_axis_tdata,
    // Result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [left_speed 14, right_speed 14, junction_found, junction_count 9,
    //  is_turning, leg_done], lowest first
    output logic [OUT_W-1:0]      m_axis_tdata,
    // Configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic                   r_in_valid;
    logic [SENSOR_BITS-1:0] r_in_l, r_in_c, r_in_r;
    logic                   r_out_valid;
    logic [OUT_W-1:0]       r_out_data;
    logic                   adv;
    t_cfg                   cfg;
    t_result                res;

    assign o_cfg_ready = 1'b1;

    lfjn_cfg_regs u_cfg (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_wr   (i_cfg_valid),
        .i_idx  (i_cfg_index),
        .i_data (i_cfg_data),
        .o_cfg  (cfg)
    );

    lfjn_nav #(
        .SENSOR_BITS(SENSOR_BITS)
    ) u_nav (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_cfg   (cfg),
        .i_left  (r_in_l),
        .i_center(r_in_c),
        .i_right (r_in_r),
        .o_res   (res)
    );

    // Stage handshake: compute moves when the result register is free or draining
    assign adv           = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_l <= s_axis_tdata[SENSOR_BITS-1:0];
            r_in_c <= s_axis_tdata[2*SENSOR_BITS-1:SENSOR_BITS];
            r_in_r <= s_axis_tdata[3*SENSOR_BITS-1:2*SENSOR_BITS];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_data <= {res.leg_done, res.is_turning, res.junction_count,
                           res.junction_found, res.right_speed, res.left_speed};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // A request held in the input stage is never dropped while the output stalls
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && !m_axis_tready |=> r_in_valid && r_out_valid)
        else $error("request lost under output stall");

endmodule

>>> dv/lfjn_checker.sv
// Checker: watches the navigator's channels, predicts every result and compares it.
`timescale 1ns / 1ps

module lfjn_checker
    import lfjn_pkg::*;
#(
    parameter int SENSOR_BITS = 12,
    parameter int IN_W        = 40
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Sensor request channel
    input  logic                  i_req_valid,
    input  logic                  i_req_ready,
    input  logic [IN_W-1:0]       i_req_data,
    // Result channel
    input  logic                  i_res_valid,
    input  logic                  i_res_ready,
    input  logic [OUT_W-1:0]      i_res_data,
    // Configuration write channel
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Status toward the testbench top
    output int                    o_err_cnt,
    output int                    o_pending,
    output int                    o_tick_cnt,
    output int                    o_junction_cnt,
    output int                    o_leg_cnt,
    output int                    o_turn_cnt
);

    typedef enum logic [1:0] {
        SENSE_OFF,
        SENSE_ON,
        SENSE_UNKNOWN
    } t_sense;

    localparam int SPEED_LO = -8192;
    localparam int SPEED_HI = 8191;

    // Shadow of the register bank and of the navigation state
    t_cfg                      regs;
    logic [COUNT_W-1:0]        nodes;
    logic                      on_node;
    logic                      turn_on;
    logic                      turn_started;
    logic [7:0]                turn_wait;
    logic signed [SPEED_W-1:0] hold_l;
    logic signed [SPEED_W-1:0] hold_r;

    // Wheel commands and flags still owed by the block, oldest first
    t_result nav_result_q[$];

    int errors;
    int ticks;
    int junctions;
    int legs;
    int turning;

    function automatic t_sense classify(input logic [SENSOR_BITS-1:0] rd);
        if (rd <= regs.track_max) return SENSE_ON;
        if (rd >= regs.board_min) return SENSE_OFF;
        return SENSE_UNKNOWN;
    endfunction

    function automatic logic signed [SPEED_W-1:0] clamp_speed(input int v);
        if (v < SPEED_LO) v = SPEED_LO;
        else if (v > SPEED_HI) v = SPEED_HI;
        return SPEED_W'(v);
    endfunction

    // One control tick: updates the shadow state, returns the expected result
    function automatic t_result step_navigator(input logic [SENSOR_BITS-1:0] l,
                                               input logic [SENSOR_BITS-1:0] c,
                                               input logic [SENSOR_BITS-1:0] r);
        t_sense  sl, sc, sr;
        logic    all_on, left_node, turning_leg, right_turn, found;
        int      d, base, corr;
        t_result res;
        found     = 1'b0;
        left_node = 1'b0;
        // Sensing is skipped when the count is already past a lowered target
        if (nodes <= regs.target_nodes) begin
            sl = classify(l);
            sc = classify(c);
            sr = classify(r);
            all_on      = (sl == SENSE_ON) && (sc == SENSE_ON) && (sr == SENSE_ON);
            right_turn  = (regs.travel_mode == MODE_RIGHT);
            turning_leg = (regs.travel_mode == MODE_LEFT || right_turn) &&
                          (!turn_started || turn_on);
            if (!on_node && all_on) begin
                if (nodes != COUNT_MAX) nodes = nodes + 1'b1;
                on_node = 1'b1;
                found   = 1'b1;
            end
            if (on_node && !all_on) begin
                on_node   = 1'b0;
                left_node = 1'b1;
            end
            if (turning_leg && (left_node || turn_on)) begin
                if (!turn_on) begin
                    turn_on   = 1'b1;
                    turn_wait = regs.turn_ticks;
                    hold_l    = right_turn ? TURN_FAST : TURN_SLOW;
                    hold_r    = right_turn ? TURN_SLOW : TURN_FAST;
                end else begin
                    if (turn_wait != 0) turn_wait = turn_wait - 1'b1;
                    // turn ends on the matching pattern once the wait is over
                    if (turn_wait == 0) begin
                        if (!right_turn && sl == SENSE_OFF && sc == SENSE_ON &&
                            sr == SENSE_ON)
                            turn_on = 1'b0;
                        else if (right_turn && sl == SENSE_ON && sc == SENSE_ON &&
                                 sr == SENSE_OFF)
                            turn_on = 1'b0;
                    end
                end
                turn_started = 1'b1;
            end else begin
                // proportional steering, Q8 gain, division truncates toward zero
                d      = int'(r) - int'(l);
                base   = int'(regs.forward_speed) * 256;
                corr   = int'(regs.steer_gain) * d;
                hold_l = clamp_speed((base - corr) / 256);
                hold_r = clamp_speed((base + corr) / 256);
            end
        end
        res.junction_count = nodes;
        res.junction_found = found;
        res.left_speed     = hold_l;
        res.right_speed    = hold_r;
        res.leg_done       = 1'b0;
        // Leg end: wheels stop, count and turn flag clear, held speeds kept
        if (nodes > regs.target_nodes) begin
            res.leg_done    = 1'b1;
            res.left_speed  = '0;
            res.right_speed = '0;
            nodes           = '0;
            turn_started    = 1'b0;
        end
        res.is_turning = turn_on;
        return res;
    endfunction

    function automatic void check_field(input string name,
                                        input logic signed [31:0] want,
                                        input logic signed [31:0] got);
        if (got !== want) begin
            errors++;
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            regs = '{target_nodes:  RST_TARGET_NODES,
                     travel_mode:   RST_TRAVEL_MODE,
                     track_max:     RST_TRACK_MAX,
                     board_min:     RST_BOARD_MIN,
                     forward_speed: RST_FORWARD_SPEED,
                     steer_gain:    RST_STEER_GAIN,
                     turn_ticks:    RST_TURN_TICKS};
            nodes        = '0;
            on_node      = 1'b0;
            turn_on      = 1'b0;
            turn_started = 1'b0;
            turn_wait    = '0;
            hold_l       = '0;
            hold_r       = '0;
            nav_result_q.delete();
        end else begin
            // Register writes
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_TARGET_NODES:  regs.target_nodes  = i_cfg_data[7:0];
                    REG_TRAVEL_MODE:   regs.travel_mode   = i_cfg_data[1:0];
                    REG_TRACK_MAX:     regs.track_max     = i_cfg_data[11:0];
                    REG_BOARD_MIN:     regs.board_min     = i_cfg_data[11:0];
                    REG_FORWARD_SPEED: regs.forward_speed = i_cfg_data[9:0];
                    REG_STEER_GAIN:    regs.steer_gain    = i_cfg_data[7:0];
                    REG_TURN_TICKS:    regs.turn_ticks    = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            // Results are checked before this edge's request is predicted
            if (i_res_valid && i_res_ready) begin
                got = t_result'(i_res_data);
                if (nav_result_q.size() == 0) begin
                    errors++;
                    $error("result %h arrived with no request outstanding", i_res_data);
                end else begin
                    want = nav_result_q.pop_front();
                    check_field("left_speed", 32'(want.left_speed), 32'(got.left_speed));
                    check_field("right_speed", 32'(want.right_speed),
                                32'(got.right_speed));
                    check_field("junction_found", 32'(want.junction_found),
                                32'(got.junction_found));
                    check_field("junction_count", 32'(want.junction_count),
                                32'(got.junction_count));
                    check_field("is_turning", 32'(want.is_turning), 32'(got.is_turning));
                    check_field("leg_done", 32'(want.leg_done), 32'(got.leg_done));
                end
            end
            if (i_req_valid && i_req_ready) begin
                want = step_navigator(i_req_data[SENSOR_BITS-1:0],
                                      i_req_data[2*SENSOR_BITS-1:SENSOR_BITS],
                                      i_req_data[3*SENSOR_BITS-1:2*SENSOR_BITS]);
                nav_result_q.push_back(want);
                ticks++;
                junctions += want.junction_found;
                legs      += want.leg_done;
                turning   += want.is_turning;
            end
        end
        o_err_cnt      <= errors;
        o_pending      <= nav_result_q.size();
        o_tick_cnt     <= ticks;
        o_junction_cnt <= junctions;
        o_leg_cnt      <= legs;
        o_turn_cnt     <= turning;
    end

endmodule

>>> dv/testbench.sv
// Testbench top: drives sensor ticks and register writes into the navigator.
`timescale 1ns / 1ps

module testbench;
    import lfjn_pkg::*;

    localparam int SENSOR_BITS   = 12;
    localparam int SENSOR_MAX    = (1 << SENSOR_BITS) - 1;
    localparam int IN_W          = ((3 * SENSOR_BITS + 7) / 8) * 8;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 4;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 140;

    // Code 3 of travel_mode has no name in the package; it drives straight
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef enum logic [2:0] {
        LVL_ON,
        LVL_OFF,
        LVL_MID,
        LVL_EDGE,
        LVL_ANY
    } t_level;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_W-1:0]       s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_W-1:0]      m_axis_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    int   err_cnt;
    int   pending_cnt;
    int   tick_cnt;
    int   junction_cnt;
    int   leg_cnt;
    int   turn_cnt;
    int   cycle_cnt    = 0;
    int   sent         = 0;
    int   settings_cnt = 1;
    bit   calm         = 1'b0;
    bit   hold_req     = 1'b0;
    t_cfg cur_cfg;

    always #5 i_clk = ~i_clk;

    line_follow_junction_navigator_core #(
        .SENSOR_BITS(SENSOR_BITS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    lfjn_checker #(
        .SENSOR_BITS(SENSOR_BITS),
        .IN_W       (IN_W)
    ) u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (s_axis_tvalid),
        .i_req_ready    (s_axis_tready),
        .i_req_data     (s_axis_tdata),
        .i_res_valid    (m_axis_tvalid),
        .i_res_ready    (m_axis_tready),
        .i_res_data     (m_axis_tdata),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_err_cnt      (err_cnt),
        .o_pending      (pending_cnt),
        .o_tick_cnt     (tick_cnt),
        .o_junction_cnt (junction_cnt),
        .o_leg_cnt      (leg_cnt),
        .o_turn_cnt     (turn_cnt)
    );

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Run stopped by watchdog after %0d cycles", cycle_cnt);
            $display("FAILURE");
            $finish;
        end
    end

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Reading that lands in the requested class under the current thresholds
    function automatic logic [SENSOR_BITS-1:0] pick_level(input t_level k);
        int tmax, bmin;
        tmax = int'(cur_cfg.track_max);
        bmin = int'(cur_cfg.board_min);
        case (k)
            LVL_ON:  return SENSOR_BITS'($urandom_range(0, tmax));
            LVL_OFF: return SENSOR_BITS'($urandom_range(bmin, SENSOR_MAX));
            LVL_MID: begin
                if (bmin - tmax > 1) return SENSOR_BITS'($urandom_range(tmax + 1, bmin - 1));
                return SENSOR_BITS'($urandom_range(0, SENSOR_MAX));
            end
            LVL_EDGE: begin
                case ($urandom_range(0, 5))
                    0: return SENSOR_BITS'(tmax);
                    1: return SENSOR_BITS'((tmax < SENSOR_MAX) ? tmax + 1 : tmax);
                    2: return SENSOR_BITS'(bmin);
                    3: return SENSOR_BITS'((bmin > 0) ? bmin - 1 : 0);
                    4: return '0;
                    default: return SENSOR_BITS'(SENSOR_MAX);
                endcase
            end
            default: return SENSOR_BITS'($urandom_range(0, SENSOR_MAX));
        endcase
    endfunction

    // Side sensor while following: mostly off the line, sometimes drifting
    function automatic t_level side_level();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return LVL_OFF;
        if (r < 8) return LVL_MID;
        return LVL_ON;
    endfunction

    function automatic t_cfg make_settings(input int target, input logic [1:0] mode,
                                           input int track, input int board,
                                           input int fwd, input int gain,
                                           input int ticks);
        t_cfg c;
        c.target_nodes  = target[7:0];
        c.travel_mode   = mode;
        c.track_max     = track[11:0];
        c.board_min     = board[11:0];
        c.forward_speed = fwd[9:0];
        c.steer_gain    = gain[7:0];
        c.turn_ticks    = ticks[7:0];
        return c;
    endfunction

    // Settings of one random phase; the first two take the extremes
    function automatic t_cfg random_settings(input int phase);
        int         r, target, track, board, fwd, gain, ticks;
        logic [1:0] mode;
        if (phase == 0) return make_settings(255, MODE_STRAIGHT, 4095, 4095, 1000, 255, 255);
        if (phase == 1) return make_settings(0, MODE_LEFT, 0, 0, 0, 0, 0);
        target = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 4) : $urandom_range(0, 255);
        r = $urandom_range(0, 19);
        if (r < 8) mode = MODE_LEFT;
        else if (r < 16) mode = MODE_RIGHT;
        else if (r < 19) mode = MODE_STRAIGHT;
        else mode = MODE_UNUSED;
        track = $urandom_range(0, 2000);
        board = ($urandom_range(0, 9) < 8) ? track + $urandom_range(1, 1500)
                                           : $urandom_range(0, SENSOR_MAX);
        r = $urandom_range(0, 9);
        fwd = (r < 2) ? 0 : (r < 4) ? 1000 : $urandom_range(0, 1000);
        r = $urandom_range(0, 9);
        gain = (r < 2) ? 0 : (r < 4) ? 255 : $urandom_range(0, 255);
        r = $urandom_range(0, 9);
        ticks = (r < 7) ? $urandom_range(0, 6) : (r < 9) ? $urandom_range(0, 255) : 255;
        return make_settings(target, mode, track, board, fwd, gain, ticks);
    endfunction

    // One sensor request; valid stays high into the next request unless a gap follows
    task automatic send_tick(input int l, input int c, input int r);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_W - 3 * SENSOR_BITS){1'b0}},
                          SENSOR_BITS'(r), SENSOR_BITS'(c), SENSOR_BITS'(l)};
        do @(posedge i_clk); while (!s_axis_tready);
        sent++;
    endtask

    task automatic send_levels(input t_level a, input t_level b, input t_level c);
        send_tick(pick_level(a), pick_level(b), pick_level(c));
    endtask

    // Wait until every result is back and the block has settled
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_cnt != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic configure(input t_cfg c);
        drain();
        write_reg(REG_TARGET_NODES, CFG_DATA_W'(c.target_nodes));
        write_reg(REG_TRAVEL_MODE, CFG_DATA_W'(c.travel_mode));
        write_reg(REG_TRACK_MAX, c.track_max);
        write_reg(REG_BOARD_MIN, c.board_min);
        write_reg(REG_FORWARD_SPEED, CFG_DATA_W'(c.forward_speed));
        write_reg(REG_STEER_GAIN, CFG_DATA_W'(c.steer_gain));
        write_reg(REG_TURN_TICKS, CFG_DATA_W'(c.turn_ticks));
        i_cfg_valid <= 1'b0;
        cur_cfg = c;
        settings_cnt++;
    endtask

    // A short piece of track: following, junctions, turn exits, noise, boundaries
    task automatic run_segment();
        int n;
        n = $urandom_range(1, 4);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: repeat (n) send_levels(side_level(), LVL_ON, side_level());
            4, 5: begin
                repeat (n) send_levels(LVL_ON, LVL_ON, LVL_ON);
                send_levels(side_level(), LVL_ON, side_level());
            end
            6: repeat (n) begin
                if ($urandom_range(0, 1)) send_levels(LVL_OFF, LVL_ON, LVL_ON);
                else send_levels(LVL_ON, LVL_ON, LVL_OFF);
            end
            7: send_levels(LVL_MID, side_level(), LVL_MID);
            8: send_levels(LVL_ANY, LVL_ANY, LVL_ANY);
            default: send_levels(LVL_EDGE, LVL_EDGE, LVL_EDGE);
        endcase
    endtask

    // Result side: random stalls, plus one long hold-off on request
    initial begin : result_sink
        int n;
        bit held;
        held = 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_req && !held) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                n = pick_gap();
                if (n > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (n) @(posedge i_clk);
                end
            end
            m_axis_tready <= 1'b1;
            n = calm ? 50 : $urandom_range(1, 8);
            repeat (n) @(posedge i_clk);
        end
    end

    // Stimulus and verdict
    initial begin : stimulus
        int start;
        cur_cfg = make_settings(RST_TARGET_NODES, RST_TRAVEL_MODE, RST_TRACK_MAX,
                                RST_BOARD_MIN, RST_FORWARD_SPEED, RST_STEER_GAIN,
                                RST_TURN_TICKS);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Defaults: junctions with boundary readings, unknown readings, full steer
        send_tick(0, 0, 0);
        send_tick(4095, 4095, 4095);
        send_tick(500, 500, 500);
        send_tick(700, 0, 4095);
        send_tick(501, 699, 600);
        send_tick(4095, 0, 0);
        send_tick(0, 0, 0);
        send_tick(0, 4095, 4095);
        send_tick(4095, 4095, 0);

        // Left leg: turn on leaving the first junction, wait, then exit pattern
        configure(make_settings(3, MODE_LEFT, 500, 700, 1000, 255, 2));
        send_tick(800, 100, 800);
        send_tick(0, 0, 0);
        send_tick(800, 100, 800);
        send_tick(800, 800, 800);
        send_tick(800, 800, 800);
        send_tick(800, 100, 100);
        send_tick(100, 100, 100);
        send_tick(800, 100, 800);

        // Right leg with zero wait; adds two junctions to the count
        configure(make_settings(255, MODE_RIGHT, 500, 700, 0, 0, 0));
        send_tick(0, 0, 0);
        send_tick(800, 100, 800);
        send_tick(100, 100, 800);
        send_tick(0, 0, 0);

        // Target lowered below the count, then the unused mode
        configure(make_settings(0, MODE_UNUSED, 0, 4095, 1000, 128, 255));
        send_tick(0, 0, 0);
        send_tick(4095, 4095, 4095);
        send_tick(0, 0, 0);

        // Random phases
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            configure(random_settings(phase));
            calm = (phase % 4 == 3);
            if (phase == 2) hold_req = 1'b1;
            start = sent;
            while (sent - start < PHASE_ITEMS) run_segment();
        end

        drain();
        $display("Run covered %0d sensor ticks under %0d register settings,",
                 tick_cnt, settings_cnt);
        $display("with %0d junction entries, %0d finished legs and %0d turning ticks.",
                 junction_cnt, leg_cnt, turn_cnt);
        if (err_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> sim.f
src/lfjn_pkg.sv
src/lfjn_cfg_regs.sv
src/lfjn_steer.sv
src/lfjn_nav.sv
src/line_follow_junction_navigator_core.sv
dv/lfjn_checker.sv
dv/testbench.sv
